// ----- hdl/brrb_pkg.sv -----
// ----------------------------------------------------------------------------
// brrb_pkg: shared types and constants of the bit-reversal reorder buffer
// field widths, command codes, reset values and the read tag format
// ----------------------------------------------------------------------------
package brrb_pkg;

	// fixed field widths
	localparam int LOG_SIZE_W = 4;
	localparam int ELEM_W     = 64;
	localparam int POS_W      = 12;

	// defaults for the top level parameters
	localparam int DEF_LOG_MAX_DEPTH = 12;
	localparam int DEF_DATA_WIDTH    = 64;

	// log_size after reset
	localparam int LOG_SIZE_RESET = 12;

	// entries of the result queue in the back end
	localparam int QUEUE_DEPTH = 4;

	// item command codes
	typedef enum logic {
		CMD_DATA  = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	// read issued by the front end, travels alongside the bank read
	typedef struct packed {
		logic             vld;
		logic [POS_W-1:0] pos;
		logic             last;
	} rd_tag_t;

endpackage

// ----- hdl/brrb_ram.sv -----
// ----------------------------------------------------------------------------
// brrb_ram: ping-pong frame storage
// two banks in one array, one write port and one registered read port
// ----------------------------------------------------------------------------
module brrb_ram #(
	parameter int LOG_MAX_DEPTH = brrb_pkg::DEF_LOG_MAX_DEPTH,
	parameter int DATA_WIDTH    = brrb_pkg::DEF_DATA_WIDTH
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [LOG_MAX_DEPTH:0]  waddr,
	input  logic [DATA_WIDTH-1:0]   wdata,
	input  logic                    re,
	input  logic [LOG_MAX_DEPTH:0]  raddr,
	output logic [DATA_WIDTH-1:0]   rdata
);

	localparam int DEPTH = 2 << LOG_MAX_DEPTH;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/brrb_front.sv -----
// ----------------------------------------------------------------------------
// brrb_front: item intake and frame bookkeeping
// writes data items in natural order, issues bit-reversed reads of the
// completed bank and swaps the banks at the end of each frame
// ----------------------------------------------------------------------------
module brrb_front #(
	parameter int LOG_MAX_DEPTH = brrb_pkg::DEF_LOG_MAX_DEPTH,
	parameter int DATA_WIDTH    = brrb_pkg::DEF_DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              command,
	input  logic [brrb_pkg::ELEM_W-1:0]       value,
	input  logic                              cfg_wr_en,
	input  logic [brrb_pkg::LOG_SIZE_W-1:0]   cfg_wr_data,
	output logic                              ram_we,
	output logic [LOG_MAX_DEPTH:0]            ram_waddr,
	output logic [DATA_WIDTH-1:0]             ram_wdata,
	output logic                              ram_re,
	output logic [LOG_MAX_DEPTH:0]            ram_raddr,
	output brrb_pkg::rd_tag_t                 rd_tag
);

	localparam int AW = LOG_MAX_DEPTH;
	localparam int LW = $clog2(LOG_MAX_DEPTH + 1);
	localparam int RST_EFF = (brrb_pkg::LOG_SIZE_RESET > LOG_MAX_DEPTH) ?
		LOG_MAX_DEPTH : brrb_pkg::LOG_SIZE_RESET;
	localparam logic [AW-1:0] RST_MASK = AW'((1 << RST_EFF) - 1);
	localparam logic [LW-1:0] RST_RSH  = LW'(AW - RST_EFF);

	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic          avail_q;
	logic          wbank_q;
	logic [AW-1:0] mask_q;
	logic [LW-1:0] rsh_q;

	logic [LW-1:0] eff_c;
	logic [AW:0]   len_c;
	logic [AW-1:0] rev_c;
	logic [AW-1:0] src_c;
	logic          is_data;

	// clamp of the written frame size
	always_comb begin
		if (cfg_wr_data == '0) begin
			eff_c = LW'(1);
		end else if (int'(cfg_wr_data) > LOG_MAX_DEPTH) begin
			eff_c = LW'(LOG_MAX_DEPTH);
		end else begin
			eff_c = LW'(cfg_wr_data);
		end
		len_c = (AW+1)'(1) << eff_c;
	end

	// reverse over the full index width, then align to the frame size
	always_comb begin
		for (int k = 0; k < AW; k++) begin
			rev_c[k] = rd_idx_q[AW-1-k];
		end
		src_c = rev_c >> rsh_q;
	end

	assign is_data = (brrb_pkg::cmd_t'(command) == brrb_pkg::CMD_DATA);

	assign ram_we    = accept && is_data;
	assign ram_waddr = {wbank_q, wr_idx_q};
	assign ram_wdata = value[DATA_WIDTH-1:0];
	assign ram_re    = accept && avail_q;
	assign ram_raddr = {~wbank_q, src_c};

	assign rd_tag.vld  = ram_re;
	assign rd_tag.pos  = brrb_pkg::POS_W'(rd_idx_q);
	assign rd_tag.last = (rd_idx_q == mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			avail_q  <= 1'b0;
			wbank_q  <= 1'b0;
			mask_q   <= RST_MASK;
			rsh_q    <= RST_RSH;
		end else if (cfg_wr_en) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			avail_q  <= 1'b0;
			wbank_q  <= 1'b0;
			mask_q   <= AW'(len_c - (AW+1)'(1));
			rsh_q    <= LW'(AW) - eff_c;
		end else if (accept) begin
			if (avail_q) begin
				if (rd_idx_q == mask_q) begin
					rd_idx_q <= '0;
					avail_q  <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
			// a full frame swaps banks and drops what was left unread
			if (is_data) begin
				if (wr_idx_q == mask_q) begin
					wr_idx_q <= '0;
					wbank_q  <= ~wbank_q;
					rd_idx_q <= '0;
					avail_q  <= 1'b1;
				end else begin
					wr_idx_q <= wr_idx_q + AW'(1);
				end
			end
		end
	end

endmodule

// ----- hdl/brrb_back.sv -----
// ----------------------------------------------------------------------------
// brrb_back: result queue
// pairs bank read data with its tag and holds results until taken
// ----------------------------------------------------------------------------
module brrb_back #(
	parameter int DATA_WIDTH = brrb_pkg::DEF_DATA_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brrb_pkg::rd_tag_t              rd_tag,
	input  logic [DATA_WIDTH-1:0]          rd_data,
	output logic                           ready,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [brrb_pkg::ELEM_W-1:0]    element,
	output logic [brrb_pkg::POS_W-1:0]     position,
	output logic                           frame_last
);

	localparam int QD = brrb_pkg::QUEUE_DEPTH;
	localparam int QA = $clog2(QD);

	brrb_pkg::rd_tag_t tag_s1;

	logic [DATA_WIDTH-1:0]        q_elem [QD];
	logic [brrb_pkg::POS_W-1:0]   q_pos  [QD];
	logic                         q_last [QD];
	logic [QA-1:0]                wr_ptr_q;
	logic [QA-1:0]                rd_ptr_q;
	logic [QA:0]                  cnt_q;

	logic push;
	logic pop;

	assign push = tag_s1.vld;
	assign pop  = rsp_valid && !rsp_stall;

	// room for what is queued plus the read in flight
	assign ready = ((cnt_q + (QA+1)'(tag_s1.vld)) < (QA+1)'(QD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= rd_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_elem[wr_ptr_q] <= rd_data;
			q_pos[wr_ptr_q]  <= tag_s1.pos;
			q_last[wr_ptr_q] <= tag_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QA+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QA+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rsp_valid  = (cnt_q != '0);
	assign element    = brrb_pkg::ELEM_W'(q_elem[rd_ptr_q]);
	assign position   = q_pos[rd_ptr_q];
	assign frame_last = q_last[rd_ptr_q];

endmodule

// ----- hdl/bit_reversal_reorder_buffer_top.sv -----
// ----------------------------------------------------------------------------
// bit_reversal_reorder_buffer_top: streaming bit-reversal reorder buffer
// reorders frames of 2^log_size elements into bit-reversed index order
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall): each item is a data element
//   (command = data, value stored as the next element of the frame being
//   filled) or a drain tick (command = drain, value ignored)
//   response channel (rsp_valid / rsp_stall): every item accepted while a
//   completed frame still has unread positions yields one result: element,
//   position within the frame and frame_last on the final position; the
//   element at position i was written at index i reversed over log_size bits
//   frames ping-pong between two banks; a frame becomes readable the moment
//   its last element is written, dropping whatever of the previous frame was
//   still unread
//   throughput is one item per cycle while req_stall is low; a result passes
//   through the registered bank read and then into the result queue
//   a stalled receiver fills the four-entry result queue; req_stall rises
//   once the queue plus the read in flight would fill it
//   reset empties the queue and sets log_size to 12 with no frame readable;
//   bank contents are undefined until written and need no clearing pass
//   a write of log_size (only while idle) restarts the stream from bank zero
// ----------------------------------------------------------------------------
module bit_reversal_reorder_buffer_top #(
	parameter int LOG_MAX_DEPTH = brrb_pkg::DEF_LOG_MAX_DEPTH,
	parameter int DATA_WIDTH    = brrb_pkg::DEF_DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [brrb_pkg::LOG_SIZE_W-1:0]   cfg_wr_data,
	// request channel
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              command,
	input  logic [brrb_pkg::ELEM_W-1:0]       value,
	// response channel
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [brrb_pkg::ELEM_W-1:0]       element,
	output logic [brrb_pkg::POS_W-1:0]        position,
	output logic                              frame_last
);

	logic                      accept;
	logic                      back_ready;
	logic                      ram_we;
	logic [LOG_MAX_DEPTH:0]    ram_waddr;
	logic [DATA_WIDTH-1:0]     ram_wdata;
	logic                      ram_re;
	logic [LOG_MAX_DEPTH:0]    ram_raddr;
	logic [DATA_WIDTH-1:0]     ram_rdata;
	brrb_pkg::rd_tag_t         rd_tag;

	// stall depends on queue occupancy and the read in flight only, never on req_valid
	assign req_stall = !back_ready;
	assign accept    = req_valid && !req_stall;

	// front end: bookkeeping, bank write, bit-reversed read address
	brrb_front #(
		.LOG_MAX_DEPTH (LOG_MAX_DEPTH),
		.DATA_WIDTH    (DATA_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.value       (value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.rd_tag      (rd_tag)
	);

	// ping-pong frame banks
	brrb_ram #(
		.LOG_MAX_DEPTH (LOG_MAX_DEPTH),
		.DATA_WIDTH    (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// back end: result queue toward the receiver
	brrb_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_tag     (rd_tag),
		.rd_data    (ram_rdata),
		.ready      (back_ready),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.element    (element),
		.position   (position),
		.frame_last (frame_last)
	);

	// write and read of one item always go to opposite banks
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr[LOG_MAX_DEPTH] != ram_raddr[LOG_MAX_DEPTH]))
		else $error("bank write and read collide in one bank");

	// an issued read shows up at the response side after the bank read register and the result queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rd_tag.vld) |-> ##2 rsp_valid)
		else $error("issued read did not reach the result queue");

	// a restart leaves no frame readable
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !ram_re)
		else $error("read issued right after restart");

endmodule

// ----- tb/tb_bit_reversal_reorder_buffer_top.sv -----
// ----------------------------------------------------------------------------
// tb_bit_reversal_reorder_buffer_top: self-checking bench of the reorder buffer
// streams data and drain items through the request channel, predicts every
// reordered result from a bench-side copy of banks and counters, and checks
// element, position and frame_last on the response channel in order
// ----------------------------------------------------------------------------
module tb_bit_reversal_reorder_buffer_top;

	// bench copy of the block parameters
	localparam int LOG_MAX    = brrb_pkg::DEF_LOG_MAX_DEPTH;
	localparam int DW         = brrb_pkg::DEF_DATA_WIDTH;
	localparam int BANK_DEPTH = 1 << LOG_MAX;
	localparam logic [brrb_pkg::ELEM_W-1:0] DATA_MASK =
		{brrb_pkg::ELEM_W{1'b1}} >> (brrb_pkg::ELEM_W - DW);

	// cycles allowed for a result to leave the block once nothing is fed in
	localparam int DRAIN_WAIT = 8;
	// give-up point, far beyond the slowest correct run
	localparam int LIMIT_CYCLES = 1000000;

	// one result as the response channel shows it
	typedef struct packed {
		logic [brrb_pkg::ELEM_W-1:0] element;
		logic [brrb_pkg::POS_W-1:0]  position;
		logic                        frame_last;
	} reorder_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [brrb_pkg::LOG_SIZE_W-1:0] cfg_wr_data;
	logic                            req_valid;
	logic                            req_stall;
	logic                            command;
	logic [brrb_pkg::ELEM_W-1:0]     value;
	logic                            rsp_valid;
	logic                            rsp_stall;
	logic [brrb_pkg::ELEM_W-1:0]     element;
	logic [brrb_pkg::POS_W-1:0]      position;
	logic                            frame_last;

	bit_reversal_reorder_buffer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.command     (command),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.element     (element),
		.position    (position),
		.frame_last  (frame_last)
	);

	// bench-side reorder state
	logic [brrb_pkg::ELEM_W-1:0]     frame_mem [2*BANK_DEPTH];
	int                              fill_idx;
	int                              drain_idx;
	int                              unread_cnt;
	int                              fill_bank;
	logic [brrb_pkg::LOG_SIZE_W-1:0] log_size_reg;

	// reordered elements still owed by the block, oldest first
	reorder_result_t reordered_q[$];

	// idle percentages of the two sides, and the long receiver hold-off
	int send_idle_pct;
	int rcv_idle_pct;
	int hold_len;

	// run statistics
	int err_count;
	int items_sent;
	int results_seen;
	int size_writes;
	int big_holds;

	// clock, 20 time units per period
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop if the block hangs
	initial begin
		#(20 * LIMIT_CYCLES);
		$display("tb_bit_reversal_reorder_buffer_top: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// log_size as the block uses it: zero acts as one, large values saturate
	function automatic int frame_log();
		int l;
		l = log_size_reg;
		if (l < 1)
			l = 1;
		if (l > LOG_MAX)
			l = LOG_MAX;
		return l;
	endfunction

	// idx reversed over nbits bits
	function automatic int bit_rev(input int idx, input int nbits);
		int r;
		r = 0;
		for (int k = 0; k < nbits; k++)
			r = (r << 1) | ((idx >> k) & 1);
		return r;
	endfunction

	// one accepted item: read from the completed bank first, then store
	task automatic predict_reorder(input brrb_pkg::cmd_t cmd,
		input logic [brrb_pkg::ELEM_W-1:0] data);
		int l;
		int len;
		int src;
		int rd_bank;
		reorder_result_t r;
		l       = frame_log();
		len     = 1 << l;
		rd_bank = fill_bank ^ 1;
		if (unread_cnt != 0) begin
			src          = bit_rev(drain_idx & (len - 1), l) & (BANK_DEPTH - 1);
			r.element    = frame_mem[rd_bank*BANK_DEPTH + src] & DATA_MASK;
			r.position   = drain_idx[brrb_pkg::POS_W-1:0];
			r.frame_last = (drain_idx + 1 >= len);
			reordered_q.push_back(r);
			drain_idx++;
			unread_cnt--;
			if (drain_idx >= len || unread_cnt == 0) begin
				drain_idx  = 0;
				unread_cnt = 0;
			end
		end
		if (cmd == brrb_pkg::CMD_DATA) begin
			frame_mem[fill_bank*BANK_DEPTH + (fill_idx & (BANK_DEPTH - 1))] = data & DATA_MASK;
			fill_idx++;
			// frame complete: swap banks, any unread rest of the old frame is gone
			if (fill_idx >= len) begin
				fill_idx   = 0;
				fill_bank  = fill_bank ^ 1;
				drain_idx  = 0;
				unread_cnt = len;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off when hold_len is armed
	// ------------------------------------------------------------------------
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				rsp_stall <= 1'b1;
				hold_len = hold_len - 1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// result checker: every accepted result against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		reorder_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (reordered_q.size() == 0) begin
				$error("unexpected result: element %h position %0d frame_last %0b",
					element, position, frame_last);
				err_count++;
			end else begin
				want = reordered_q.pop_front();
				if (element !== want.element) begin
					$error("element: expected %h, actual %h", want.element, element);
					err_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					err_count++;
				end
				if (frame_last !== want.frame_last) begin
					$error("frame_last: expected %0b, actual %0b", want.frame_last, frame_last);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offer one item, with random sender gaps before it; returns at the
	// clock edge where it was taken
	task automatic send_item(input brrb_pkg::cmd_t cmd,
		input logic [brrb_pkg::ELEM_W-1:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command   <= cmd;
		value     <= data;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		predict_reorder(cmd, data);
	endtask

	// element data: mostly random, now and then an extreme pattern
	function automatic logic [brrb_pkg::ELEM_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {{(brrb_pkg::ELEM_W-1){1'b0}}, 1'b1} << $urandom_range(0, brrb_pkg::ELEM_W - 1);
			3: return ~({{(brrb_pkg::ELEM_W-1){1'b0}}, 1'b1} << $urandom_range(0, brrb_pkg::ELEM_W - 1));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// stop offering, let every owed result out, then cover the pipeline
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (reordered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// new frame size, written only while the block is idle
	task automatic write_log_size(input logic [brrb_pkg::LOG_SIZE_W-1:0] lg);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lg;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= brrb_pkg::LOG_SIZE_W'($urandom);
		size_writes++;
		// a size write restarts the stream, bank contents stay
		log_size_reg = lg;
		fill_idx     = 0;
		drain_idx    = 0;
		unread_cnt   = 0;
		fill_bank    = 0;
	endtask

	// nframes full frames of data, each element preceded by drains at drain_pct
	task automatic send_frames(input int nframes, input int drain_pct);
		int len;
		len = 1 << frame_log();
		for (int f = 0; f < nframes; f++) begin
			for (int i = 0; i < len; i++) begin
				while ($urandom_range(0, 99) < drain_pct)
					send_item(brrb_pkg::CMD_DRAIN, pick_value());
				send_item(brrb_pkg::CMD_DATA, pick_value());
			end
		end
	endtask

	task automatic send_drains(input int n);
		for (int i = 0; i < n; i++)
			send_item(brrb_pkg::CMD_DRAIN, pick_value());
	endtask

	// n items, about one in four a drain, none of them completing a large frame
	task automatic send_mixed(input int n);
		for (int i = 0; i < n; i++)
			send_item($urandom_range(0, 3) == 0 ? brrb_pkg::CMD_DRAIN : brrb_pkg::CMD_DATA,
				pick_value());
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset size of 4096: a run of mixed items far short of one frame, so
	// nothing may be read out yet
	task automatic test_reset_size_frame();
		send_item(brrb_pkg::CMD_DATA, '0);
		send_item(brrb_pkg::CMD_DATA, '1);
		send_mixed(150);
	endtask

	// smallest frame: drains with nothing readable, then two-element frames
	task automatic test_smallest_frame();
		write_log_size(4'd1);
		send_item(brrb_pkg::CMD_DRAIN, '1);
		send_item(brrb_pkg::CMD_DATA, '0);
		send_item(brrb_pkg::CMD_DATA, '1);
		send_item(brrb_pkg::CMD_DRAIN, '0);
		send_item(brrb_pkg::CMD_DRAIN, '1);
		send_item(brrb_pkg::CMD_DRAIN, 64'h5555_5555_5555_5555);
		send_item(brrb_pkg::CMD_DATA, 64'haaaa_aaaa_aaaa_aaaa);
		send_item(brrb_pkg::CMD_DATA, 64'h5555_5555_5555_5555);
		send_item(brrb_pkg::CMD_DATA, 64'h8000_0000_0000_0001);
		send_item(brrb_pkg::CMD_DATA, 64'h7fff_ffff_ffff_fffe);
		send_item(brrb_pkg::CMD_DRAIN, '0);
		send_item(brrb_pkg::CMD_DRAIN, '0);
	endtask

	// a zero size behaves like one
	task automatic test_zero_size_clamp();
		write_log_size(4'd0);
		send_frames(3, 0);
		send_drains(3);
	endtask

	// sizes above the bank depth saturate at 4096, so a short run reads nothing
	task automatic test_oversize_clamp();
		write_log_size(4'd15);
		send_mixed(60);
	endtask

	// eight-element frames with drains mixed in, reading some frames short
	task automatic test_drain_mix();
		write_log_size(4'd3);
		send_frames(3, 30);
		send_drains(10);
	endtask

	// receiver holds off while the sender keeps offering, filling the block
	task automatic test_receiver_hold();
		write_log_size(4'd2);
		@(negedge clk);
		hold_len = 300;
		big_holds++;
		@(posedge clk);
		send_frames(12, 15);
		send_drains(5);
	endtask

	// random frame sizes and item mixes until about n_items were sent
	task automatic test_random_stream(input int n_items, input int s_pct, input int r_pct);
		int start;
		int pick;
		int lg;
		int len;
		send_idle_pct = s_pct;
		rcv_idle_pct  = r_pct;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				lg = $urandom_range(0, 5);
			else if (pick < 18)
				lg = $urandom_range(6, 8);
			else
				lg = $urandom_range(9, 15);
			write_log_size(lg[brrb_pkg::LOG_SIZE_W-1:0]);
			len = 1 << frame_log();
			if (lg > 8) begin
				// frame too large to finish here, items are only stored
				send_mixed(20);
			end else begin
				send_frames(lg <= 5 ? $urandom_range(1, 4) : 1, $urandom_range(0, 40));
				send_drains($urandom_range(0, len + 1));
				// noise: short unfinished run of mixed items
				if ($urandom_range(0, 3) == 0)
					for (int i = 0; i < $urandom_range(1, 6); i++)
						send_item($urandom_range(0, 1) ? brrb_pkg::CMD_DRAIN : brrb_pkg::CMD_DATA,
							pick_value());
			end
			// now and then a long hold-off in the middle of a stream
			if ($urandom_range(0, 15) == 0) begin
				req_valid <= 1'b0;
				@(negedge clk);
				hold_len = $urandom_range(40, 120);
				big_holds++;
				@(posedge clk);
				send_frames(2, 10);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		req_valid     = 1'b0;
		command       = brrb_pkg::CMD_DATA;
		value         = '0;
		hold_len      = 0;
		send_idle_pct = 33;
		rcv_idle_pct  = 48;
		err_count     = 0;
		items_sent    = 0;
		results_seen  = 0;
		size_writes   = 0;
		big_holds     = 0;
		log_size_reg  = brrb_pkg::LOG_SIZE_RESET;
		fill_idx      = 0;
		drain_idx     = 0;
		unread_cnt    = 0;
		fill_bank     = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size_frame();
		test_smallest_frame();
		test_zero_size_clamp();
		test_oversize_clamp();
		test_drain_mix();
		test_receiver_hold();

		// idle pattern: sender-light first, then receiver-light, then none
		test_random_stream(280, 33, 48);
		test_random_stream(280, 48, 33);
		test_random_stream(280, 0, 0);

		// let everything owed come out
		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (reordered_q.size() != 0) begin
			$error("%0d expected results never arrived", reordered_q.size());
			err_count++;
		end

		$display("covered %0d items, %0d reordered results checked, %0d frame size writes",
			items_sent, results_seen, size_writes);
		$display("frames of 2 to 256 read out, larger and clamped sizes stored, %0d long hold-offs",
			big_holds);
		if (err_count == 0)
			$display("tb_bit_reversal_reorder_buffer_top: clean");
		else
			$display("tb_bit_reversal_reorder_buffer_top: errors");
		$finish;
	end

endmodule

// ----- bit_reversal_reorder_buffer_top.f -----
hdl/brrb_pkg.sv
hdl/brrb_ram.sv
hdl/brrb_front.sv
hdl/brrb_back.sv
hdl/bit_reversal_reorder_buffer_top.sv
tb/tb_bit_reversal_reorder_buffer_top.sv
